[rtl/core/hbp_pkg.sv]
package hbp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHOOSER_BITS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GSHARE_BITS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HISTORY_BITS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIMODAL_BITS  = 3'd4;

   localparam logic [1:0] MODE_BIMODAL = 2'd0;
   localparam logic [1:0] MODE_GSHARE  = 2'd1;
   localparam logic [1:0] MODE_HYBRID  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] RESET_CHOOSER_BITS = 4'd8;
   localparam logic [CSR_DATA_W-1:0] RESET_GSHARE_BITS  = 4'd9;
   localparam logic [CSR_DATA_W-1:0] RESET_HISTORY_BITS = 4'd3;
   localparam logic [CSR_DATA_W-1:0] RESET_BIMODAL_BITS = 4'd5;

   // index widths up to 31 bits fit here
   typedef logic [4:0] width_type;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_WEAK_TAKEN   = 2'd2;
   localparam ctr_type CTR_WEAK_BIMODAL = 2'd1;
   localparam ctr_type CTR_MAX          = 2'd3;
   localparam ctr_type CTR_MIN          = 2'd0;

   localparam int RSP_QUEUE_DEPTH = 3;
   localparam int RSP_PTR_W       = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_CNT_W       = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef logic [RSP_PTR_W-1:0] rsp_ptr_type;
   typedef logic [RSP_CNT_W-1:0] rsp_cnt_type;

   typedef struct packed {
      logic predicted_taken;
      logic mispredicted;
      logic used_gshare;
   } rsp_type;

   function automatic ctr_type train(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 2'd1;
      end else begin
         if (c != CTR_MIN) r = c - 2'd1;
      end
      return r;
   endfunction

endpackage

[rtl/core/hbp_ram.sv]
module hbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/hbp_rsp_queue.sv]
module hbp_rsp_queue
   import hbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  rsp_type     push_data,
   input  logic        pop_stall,
   output logic        out_valid,
   output rsp_type     out_data,
   output rsp_cnt_type count
);

   rsp_type     entries_ff [RSP_QUEUE_DEPTH];
   rsp_ptr_type head_ff, head_in;
   rsp_ptr_type tail_ff, tail_in;
   rsp_cnt_type count_ff, count_in;
   logic        pop;

   function automatic rsp_ptr_type next_ptr(input rsp_ptr_type p);
      rsp_ptr_type r;
      if (p == RSP_PTR_W'(RSP_QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + RSP_PTR_W'(1);
      end
      return r;
   endfunction

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[head_ff];
   assign count     = count_ff;
   assign pop       = out_valid && !pop_stall;

   always_comb begin
      head_in  = pop ? next_ptr(head_ff) : head_ff;
      tail_in  = push_valid ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (!push_valid && pop) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

endmodule

[rtl/core/hybrid_branch_predictor.sv]
// Channel   Ports                                              Direction
// req       req_valid/req_stall, branch_address, actual_taken  in
// rsp       rsp_valid/rsp_stall, predicted_taken, mispredicted,
//           used_gshare                                        out
// csr       csr_write_enable, csr_index, csr_data              in, write only
//
// One branch per cycle while req_stall is low; the tables are read at the
// transfer edge, trained and written back at the next edge, where the result
// enters the queue and raises rsp_valid; the result can transfer from then on.
// Each item reads every table and writes back the chooser in hybrid mode and
// the table it predicted with. After reset a sweep writes the initial counters,
// one entry per cycle; req_stall is high during it.
// A three-entry result queue absorbs rsp stalls; req stalls once it may fill.
module hybrid_branch_predictor
   import hbp_pkg::*;
#(
   parameter int MAX_BIMODAL_BITS = 12,
   parameter int MAX_GSHARE_BITS  = 12,
   parameter int MAX_CHOOSER_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_branch_address,
   input  logic                   req_actual_taken,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_predicted_taken,
   output logic                   rsp_mispredicted,
   output logic                   rsp_used_gshare,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int BB   = MAX_BIMODAL_BITS;
   localparam int GB   = MAX_GSHARE_BITS;
   localparam int CB   = MAX_CHOOSER_BITS;
   localparam int MAXB = (BB > GB) ? ((BB > CB) ? BB : CB) : ((GB > CB) ? GB : CB);
   localparam int HMAX = (1 << CSR_DATA_W) - 1;
   localparam int HW   = (GB < HMAX) ? GB : HMAX;

   function automatic width_type clamp_bits(input logic [CSR_DATA_W-1:0] w,
                                            input width_type maxw);
      width_type v;
      v = width_type'(w);
      if (v == '0) v = width_type'(1);
      if (v > maxw) v = maxw;
      return v;
   endfunction

   logic [1:0]            mode_ff;
   logic [CSR_DATA_W-1:0] chooser_bits_ff, gshare_bits_ff, history_bits_ff, bimodal_bits_ff;

   logic [MAXB:0]         clr_cnt_ff;
   logic                  clearing;

   logic [HW-1:0]         hist_ff, hist_in, hist_m;

   logic                  s1_valid_ff, s1_taken_ff;
   logic [BB-1:0]         s1_bidx_ff;
   logic [GB-1:0]         s1_gidx_ff;
   logic [CB-1:0]         s1_cidx_ff;

   logic                  b_fwd_valid_ff, g_fwd_valid_ff, c_fwd_valid_ff;
   logic [BB-1:0]         b_fwd_addr_ff;
   logic [GB-1:0]         g_fwd_addr_ff;
   logic [CB-1:0]         c_fwd_addr_ff;
   ctr_type               b_fwd_data_ff, g_fwd_data_ff, c_fwd_data_ff;

   logic                  accept;
   logic [29:0]           pc;
   width_type             bb_w, gb_w, cb_w, nb_w, s_w;
   logic [BB-1:0]         bidx;
   logic [GB-1:0]         gpc, gidx;
   logic [CB-1:0]         cidx;

   ctr_type               b_rd, g_rd, c_rd;
   ctr_type               b_cnt, g_cnt, c_cnt;
   ctr_type               b_new, g_new, c_new;
   logic                  bpred, gpred, use_g, hybrid, pred;
   logic                  b_we_item, g_we_item, c_we_item;

   logic                  b_we, g_we, c_we;
   logic [BB-1:0]         b_waddr;
   logic [GB-1:0]         g_waddr;
   logic [CB-1:0]         c_waddr;
   ctr_type               b_wdata, g_wdata, c_wdata;

   rsp_type               push_data, out_data;
   rsp_cnt_type           q_count;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_HYBRID;
         chooser_bits_ff <= RESET_CHOOSER_BITS;
         gshare_bits_ff  <= RESET_GSHARE_BITS;
         history_bits_ff <= RESET_HISTORY_BITS;
         bimodal_bits_ff <= RESET_BIMODAL_BITS;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:         mode_ff         <= csr_data[1:0];
            CSR_CHOOSER_BITS: chooser_bits_ff <= csr_data;
            CSR_GSHARE_BITS:  gshare_bits_ff  <= csr_data;
            CSR_HISTORY_BITS: history_bits_ff <= csr_data;
            CSR_BIMODAL_BITS: bimodal_bits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // initial counter sweep
   assign clearing = !clr_cnt_ff[MAXB];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clearing) begin
         clr_cnt_ff <= clr_cnt_ff + (MAXB+1)'(1);
      end
   end

   // index stage
   assign accept = req_valid && !req_stall;
   assign pc     = req_branch_address[31:2];

   assign bb_w = clamp_bits(bimodal_bits_ff, width_type'(BB));
   assign gb_w = clamp_bits(gshare_bits_ff, width_type'(GB));
   assign cb_w = clamp_bits(chooser_bits_ff, width_type'(CB));
   assign nb_w = (width_type'(history_bits_ff) < gb_w) ? width_type'(history_bits_ff) : gb_w;
   assign s_w  = gb_w - nb_w;

   assign bidx   = pc[BB-1:0] & ~({BB{1'b1}} << bb_w);
   assign cidx   = pc[CB-1:0] & ~({CB{1'b1}} << cb_w);
   assign gpc    = pc[GB-1:0] & ~({GB{1'b1}} << gb_w);
   assign hist_m = hist_ff & ~({HW{1'b1}} << nb_w);
   assign gidx   = gpc ^ (GB'(hist_m) << s_w);

   assign hist_in = (hist_m >> 1) | (HW'(req_actual_taken) << (nb_w - width_type'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept && (nb_w != '0)) begin
            hist_ff <= hist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_taken_ff <= req_actual_taken;
         s1_bidx_ff  <= bidx;
         s1_gidx_ff  <= gidx;
         s1_cidx_ff  <= cidx;
      end
   end

   // tables
   hbp_ram #(.WIDTH(2), .DEPTH(1 << BB)) u_bimodal (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (accept),
      .rd_addr (bidx),
      .rd_data (b_rd)
   );

   hbp_ram #(.WIDTH(2), .DEPTH(1 << GB)) u_gshare (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (g_wdata),
      .rd_en   (accept),
      .rd_addr (gidx),
      .rd_data (g_rd)
   );

   hbp_ram #(.WIDTH(2), .DEPTH(1 << CB)) u_chooser (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_en   (accept),
      .rd_addr (cidx),
      .rd_data (c_rd)
   );

   // predict and train stage; bypass the write made at the read edge
   assign b_cnt = (b_fwd_valid_ff && (b_fwd_addr_ff == s1_bidx_ff)) ? b_fwd_data_ff : b_rd;
   assign g_cnt = (g_fwd_valid_ff && (g_fwd_addr_ff == s1_gidx_ff)) ? g_fwd_data_ff : g_rd;
   assign c_cnt = (c_fwd_valid_ff && (c_fwd_addr_ff == s1_cidx_ff)) ? c_fwd_data_ff : c_rd;

   assign bpred  = b_cnt[1];
   assign gpred  = g_cnt[1];
   assign hybrid = (mode_ff != MODE_BIMODAL) && (mode_ff != MODE_GSHARE);

   always_comb begin
      case (mode_ff)
         MODE_BIMODAL: use_g = 1'b0;
         MODE_GSHARE:  use_g = 1'b1;
         default:      use_g = c_cnt[1];
      endcase
   end

   assign pred  = use_g ? gpred : bpred;
   assign b_new = train(b_cnt, s1_taken_ff);
   assign g_new = train(g_cnt, s1_taken_ff);

   always_comb begin
      c_new = c_cnt;
      if ((gpred == s1_taken_ff) && (bpred != s1_taken_ff)) begin
         c_new = train(c_cnt, 1'b1);
      end else if ((gpred != s1_taken_ff) && (bpred == s1_taken_ff)) begin
         c_new = train(c_cnt, 1'b0);
      end
   end

   assign b_we_item = s1_valid_ff && !use_g;
   assign g_we_item = s1_valid_ff && use_g;
   assign c_we_item = s1_valid_ff && hybrid;

   assign b_we    = clearing ? ((clr_cnt_ff >> BB) == '0) : b_we_item;
   assign g_we    = clearing ? ((clr_cnt_ff >> GB) == '0) : g_we_item;
   assign c_we    = clearing ? ((clr_cnt_ff >> CB) == '0) : c_we_item;
   assign b_waddr = clearing ? clr_cnt_ff[BB-1:0] : s1_bidx_ff;
   assign g_waddr = clearing ? clr_cnt_ff[GB-1:0] : s1_gidx_ff;
   assign c_waddr = clearing ? clr_cnt_ff[CB-1:0] : s1_cidx_ff;
   assign b_wdata = clearing ? CTR_WEAK_TAKEN   : b_new;
   assign g_wdata = clearing ? CTR_WEAK_TAKEN   : g_new;
   assign c_wdata = clearing ? CTR_WEAK_BIMODAL : c_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_fwd_valid_ff <= 1'b0;
         g_fwd_valid_ff <= 1'b0;
         c_fwd_valid_ff <= 1'b0;
      end else begin
         b_fwd_valid_ff <= b_we_item;
         g_fwd_valid_ff <= g_we_item;
         c_fwd_valid_ff <= c_we_item;
      end
   end

   always_ff @(posedge clock) begin
      b_fwd_addr_ff <= s1_bidx_ff;
      g_fwd_addr_ff <= s1_gidx_ff;
      c_fwd_addr_ff <= s1_cidx_ff;
      b_fwd_data_ff <= b_new;
      g_fwd_data_ff <= g_new;
      c_fwd_data_ff <= c_new;
   end

   // results
   assign push_data.predicted_taken = pred;
   assign push_data.mispredicted    = pred ^ s1_taken_ff;
   assign push_data.used_gshare     = use_g;

   hbp_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (push_data),
      .pop_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_data   (out_data),
      .count      (q_count)
   );

   assign rsp_predicted_taken = out_data.predicted_taken;
   assign rsp_mispredicted    = out_data.mispredicted;
   assign rsp_used_gshare     = out_data.used_gshare;

   assign req_stall = clearing ||
      ((RSP_CNT_W+1)'(s1_valid_ff) + (RSP_CNT_W+1)'(q_count) >=
       (RSP_CNT_W+1)'(RSP_QUEUE_DEPTH));

`ifndef SYNTH
   a_no_item_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !s1_valid_ff)
      else $error("branch in flight during table sweep");

   a_one_counter_trained: assert property (@(posedge clock) disable iff (reset)
      !(b_we_item && g_we_item))
      else $error("bimodal and gshare trained together");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_count != RSP_CNT_W'(RSP_QUEUE_DEPTH)))
      else $error("result queue full with a result arriving");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_valid)
      else $error("trained branch left no result");
`endif

endmodule
